// ===== design/tlpm_pkg.sv =====
// tlpm_pkg: shared types, constants and command/status codes
// used by the paging memory controller, datapath and top level
package tlpm_pkg;

    localparam int MEM_ADDR_BITS_DEF = 16;

    localparam logic [1:0] CMD_PRD = 2'd0;
    localparam logic [1:0] CMD_PWR = 2'd1;
    localparam logic [1:0] CMD_VRD = 2'd2;
    localparam logic [1:0] CMD_VWR = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_NO_DIR = 2'd2;
    localparam logic [1:0] ST_NO_TAB = 2'd3;

    localparam logic [11:0] PAGE_MASK = 12'hfff;

    // datapath operations requested by the controller
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1; // latch input item
    localparam logic [2:0] OP_PDE   = 3'd2; // read directory byte
    localparam logic [2:0] OP_PTE   = 3'd3; // read table byte
    localparam logic [2:0] OP_DATA  = 3'd4; // data byte access
    localparam logic [2:0] OP_FAULT = 3'd5; // record fault status
    localparam logic [2:0] OP_FRAME = 3'd6; // keep translated frame of a part

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] part;     // 0 first part, 1 second part; OP_FRAME uses 1 and 2
        logic [1:0] idx;      // byte index within word or access
        logic [1:0] fault;    // status for OP_FAULT
    } t_cmd;

    typedef struct packed {
        logic       paged;     // translate this item
        logic       split;     // access crosses a page
        logic [2:0] len;       // saturated length, 0 for none
        logic [2:0] len1;      // bytes in first part
        logic       wr;
        logic       dir_oor;   // directory entry address beyond memory
        logic       tab_oor;   // table entry address beyond memory
        logic       entry_p;   // assembled entry present bit
        logic       data_oor;  // some data byte beyond memory
    } t_stat;

endpackage

// ===== design/tlpm_datapath.sv =====
// tlpm_datapath: byte memory, walk registers and result assembly
// depends on tlpm_pkg
module tlpm_datapath
    import tlpm_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_address,
    input  logic [2:0]  i_access_len,
    input  logic [31:0] i_write_data,
    input  logic        i_paging_on,
    input  logic [19:0] i_directory_base,
    output t_stat       o_stat,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_status
);

    localparam int AW = MEM_ADDR_BITS;

    logic [7:0]  r_mem [2**AW];
    logic [1:0]  r_cmd;
    logic [31:0] r_addr;
    logic [2:0]  r_len;
    logic [31:0] r_wdata;
    logic        r_paged;
    logic [31:0] r_entry;
    logic [19:0] r_tab_base;
    logic [19:0] r_frame1;
    logic [19:0] r_frame2;
    logic [31:0] r_rd;
    logic [1:0]  r_st;
    logic [7:0]  r_q;

    logic [2:0]  len_sat;
    logic [12:0] off_end;
    logic [2:0]  len1;
    logic        split;
    logic [31:0] va;
    logic [19:0] tab_base;
    logic [32:0] dir_addr;
    logic [32:0] tab_addr;
    logic [32:0] word_addr;
    logic [32:0] byte_addr;
    logic [32:0] pa;
    logic [32:0] last_pa;
    logic        oor_first;
    logic        oor_second;
    logic [2:0]  idx_ext;
    logic [AW-1:0] mem_a;

    assign len_sat = (r_len > 3'd4) ? 3'd4 : r_len;
    assign off_end = {1'b0, r_addr[11:0]} + {10'd0, len_sat};
    assign split   = r_paged && (off_end > 13'h1000);
    assign len1    = split ? 3'(13'h1000 - {1'b0, r_addr[11:0]}) : len_sat;
    assign va      = (i_cmd.part == 2'd0) ? r_addr : r_addr + {29'd0, len1};
    // table base comes from the entry register on the first byte, then from
    // its copy, since the entry register fills with table bytes meanwhile
    assign tab_base = (i_cmd.idx == 2'd0) ? r_entry[31:12] : r_tab_base;
    assign dir_addr = {1'b0, i_directory_base, 12'd0} + {21'd0, va[31:22], 2'b00};
    assign tab_addr = {1'b0, tab_base, 12'd0} + {21'd0, va[21:12], 2'b00};
    assign word_addr = (i_cmd.op == OP_PTE) ? tab_addr : dir_addr;
    assign idx_ext  = {1'b0, i_cmd.idx};

    // physical address of data byte idx
    always_comb begin
        if (!r_paged)
            pa = {1'b0, r_addr} + {30'd0, idx_ext};
        else if (idx_ext < len1)
            pa = {1'b0, r_frame1, r_addr[11:0]} + {30'd0, idx_ext};
        else
            pa = {1'b0, r_frame2, 12'd0} + {30'd0, idx_ext - len1};
    end

    // range check on the last byte of each part
    assign oor_first  = r_paged
        ? (({1'b0, r_frame1, r_addr[11:0]} + {30'd0, len1 - 3'd1}) >> AW) != 0
        : (({1'b0, r_addr} + {30'd0, len_sat - 3'd1}) >> AW) != 0;
    assign last_pa    = {1'b0, r_frame2, 12'd0} + {30'd0, len_sat - len1 - 3'd1};
    assign oor_second = split && ((last_pa >> AW) != 0);

    assign byte_addr = (i_cmd.op == OP_DATA) ? pa : word_addr + {30'd0, idx_ext};
    assign mem_a     = byte_addr[AW-1:0];

    assign o_stat.paged    = r_paged;
    assign o_stat.split    = split;
    assign o_stat.len      = len_sat;
    assign o_stat.len1     = len1;
    assign o_stat.wr       = r_cmd[0];
    assign o_stat.dir_oor  = ((dir_addr + 33'd3) >> AW) != 0;
    assign o_stat.tab_oor  = ((tab_addr + 33'd3) >> AW) != 0;
    assign o_stat.entry_p  = r_entry[0];
    assign o_stat.data_oor = oor_first || oor_second;

    // memory: one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_DATA && r_cmd[0])
            r_mem[mem_a] <= r_wdata[8*i_cmd.idx +: 8];
        r_q <= r_mem[mem_a];
    end

    // read data lands in the cycle after the request; controller pipelines it
    logic [2:0] r_pend_op;
    logic [1:0] r_pend_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_op <= OP_NONE;
            r_st      <= ST_OK;
        end else begin
            r_pend_op <= i_cmd.op;
            if (i_cmd.op == OP_LOAD)
                r_st <= ST_OK;
            else if (i_cmd.op == OP_FAULT)
                r_st <= i_cmd.fault;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= i_cmd.idx;
        if (i_cmd.op == OP_LOAD) begin
            r_cmd   <= i_command;
            r_addr  <= i_address;
            r_len   <= i_access_len;
            r_wdata <= i_write_data;
            r_paged <= i_command[1] && i_paging_on;
            r_rd    <= '0;
        end
        if (i_cmd.op == OP_PTE && i_cmd.idx == 2'd0)
            r_tab_base <= r_entry[31:12];
        if (r_pend_op == OP_PDE || r_pend_op == OP_PTE)
            r_entry[8*r_pend_idx +: 8] <= r_q;
        if (r_pend_op == OP_DATA && !r_cmd[0])
            r_rd[8*r_pend_idx +: 8] <= r_q;
        if (i_cmd.op == OP_FAULT)
            r_rd <= '0;
        if (i_cmd.op == OP_DATA && i_cmd.idx == 2'd0 && i_cmd.part == 2'd1) begin
            // marker only
        end
        if (i_cmd.op == OP_FRAME && i_cmd.part == 2'd1)
            r_frame1 <= r_entry[31:12];
        if (i_cmd.op == OP_FRAME && i_cmd.part == 2'd2)
            r_frame2 <= r_entry[31:12];
    end

    assign o_read_data = r_rd;
    assign o_status    = r_st;

endmodule

// ===== design/tlpm_ctrl.sv =====
// tlpm_ctrl: sequencer for walks, data bytes and result handshake
// depends on tlpm_pkg
module tlpm_ctrl
    import tlpm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_PDE   = 4'd2;
    localparam logic [3:0] S_PDEW  = 4'd3;
    localparam logic [3:0] S_PTEC  = 4'd4;
    localparam logic [3:0] S_PTE   = 4'd5;
    localparam logic [3:0] S_PTEW  = 4'd6;
    localparam logic [3:0] S_FRAME = 4'd7;
    localparam logic [3:0] S_RCHK  = 4'd8;
    localparam logic [3:0] S_DATA  = 4'd9;
    localparam logic [3:0] S_DWAIT = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic       r_part, n_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_part  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_part  <= n_part;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_part  = r_part;
        o_cmd   = '{op: OP_NONE, part: {1'b0, r_part}, idx: r_idx, fault: ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                    n_part   = 1'b0;
                    n_idx    = '0;
                end
            end
            S_CHK: begin
                if (i_stat.len == 3'd0)
                    n_state = S_OUT;
                else if (i_stat.paged)
                    n_state = S_PDE;
                else
                    n_state = S_RCHK;
            end
            S_PDE: begin
                if (r_idx == 2'd0 && i_stat.dir_oor) begin
                    o_cmd.op = OP_FAULT;
                    o_cmd.fault = ST_RANGE;
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_PDE;
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3)
                        n_state = S_PDEW;
                end
            end
            S_PDEW: n_state = S_PTEC;
            S_PTEC: begin
                if (!i_stat.entry_p) begin
                    o_cmd.op = OP_FAULT;
                    o_cmd.fault = ST_NO_DIR;
                    n_state = S_OUT;
                end else
                    n_state = S_PTE;
            end
            S_PTE: begin
                if (r_idx == 2'd0 && i_stat.tab_oor) begin
                    o_cmd.op = OP_FAULT;
                    o_cmd.fault = ST_RANGE;
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_PTE;
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3)
                        n_state = S_PTEW;
                end
            end
            S_PTEW: n_state = S_FRAME;
            S_FRAME: begin
                if (!i_stat.entry_p) begin
                    o_cmd.op = OP_FAULT;
                    o_cmd.fault = ST_NO_TAB;
                    n_state = S_OUT;
                end else begin
                    o_cmd.op   = OP_FRAME;
                    o_cmd.part = r_part ? 2'd2 : 2'd1;
                    if (!r_part && i_stat.split) begin
                        n_part  = 1'b1;
                        n_state = S_PDE;
                    end else
                        n_state = S_RCHK;
                end
            end
            S_RCHK: begin
                n_idx = '0;
                if (i_stat.data_oor) begin
                    o_cmd.op = OP_FAULT;
                    o_cmd.fault = ST_RANGE;
                    n_state = S_OUT;
                end else
                    n_state = S_DATA;
            end
            S_DATA: begin
                o_cmd.op = OP_DATA;
                n_idx = r_idx + 2'd1;
                if ({1'b0, r_idx} == i_stat.len - 3'd1)
                    n_state = S_DWAIT;
            end
            S_DWAIT: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== design/two_level_paging_memory_access_top.sv =====
// two_level_paging_memory_access_top: stream front end, apb registers,
// controller and datapath; depends on tlpm_pkg, tlpm_ctrl, tlpm_datapath
// a physical access runs a check, a range check and its data bytes before the result;
// each part of a paged access adds a directory and a table walk; faults end early
// throughput: one item at a time, the next taken only after the result is accepted
// reset: synchronous active low, clears control and registers; memory is not cleared
module two_level_paging_memory_access_top
    import tlpm_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], address[33:2], access_len[36:34], write_data[68:37], zero pad
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[31:0], status[33:32], zero pad
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] REG_PAGING = 3'd0;
    localparam logic [2:0] REG_DIR    = 3'd4;

    logic        r_paging_on;
    logic [19:0] r_directory_base;
    t_cmd        cmd;
    t_stat       stat;
    logic [31:0] read_data;
    logic [1:0]  status;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paging_on      <= 1'b0;
            r_directory_base <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr == REG_PAGING)
                r_paging_on <= pwdata[0];
            else if (paddr == REG_DIR)
                r_directory_base <= pwdata[19:0];
        end
    end

    always_comb begin
        unique case (paddr)
            REG_PAGING: prdata = {31'd0, r_paging_on};
            REG_DIR:    prdata = {12'd0, r_directory_base};
            default:    prdata = '0;
        endcase
    end

    tlpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tlpm_datapath #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_command        (s_axis_tdata[1:0]),
        .i_address        (s_axis_tdata[33:2]),
        .i_access_len     (s_axis_tdata[36:34]),
        .i_write_data     (s_axis_tdata[68:37]),
        .i_paging_on      (r_paging_on),
        .i_directory_base (r_directory_base),
        .o_stat           (stat),
        .o_read_data      (read_data),
        .o_status         (status)
    );

    // result held stable in datapath registers while valid
    assign m_axis_tdata = {6'd0, status, read_data};

endmodule

// ===== design/tlpm_checker.sv =====
// tlpm_checker: port-level assertions for the paging memory block
// depends on tlpm_pkg; bound to two_level_paging_memory_access_top
module tlpm_checker
    import tlpm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // one item at a time: no input taken while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

    // accepted transaction cannot yield a result in the next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("result too early");

    // a fault carries zero data
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[33:32] != ST_OK) |-> m_axis_tdata[31:0] == 32'd0)
        else $error("fault with data");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed under stall");

endmodule

bind two_level_paging_memory_access_top tlpm_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/two_level_paging_memory_access_top_tb.sv =====
// two_level_paging_memory_access_top_tb: self-checking bench for the paging memory block
// depends on tlpm_pkg and two_level_paging_memory_access_top; stream in/out, apb registers
module two_level_paging_memory_access_top_tb;
    import tlpm_pkg::*;

    localparam longint MEM_BYTES   = longint'(1) << MEM_ADDR_BITS_DEF;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     SETTLE      = 60;     // longer than the worst split walk
    // apb byte addresses of the two registers
    localparam logic [2:0] REG_PAGING   = 3'd0;
    localparam logic [2:0] REG_DIR_BASE = 3'd4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // command[1:0], address[33:2], access_len[36:34], write_data[68:37], zero pad
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // read_data[31:0], status[33:32], zero pad
    logic [39:0] m_axis_tdata;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    two_level_paging_memory_access_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected response of one access transaction
    typedef struct {
        logic [31:0] rd;
        logic [1:0]  st;
    } t_access_result;

    // one directed stimulus row; fixed marks rows whose answer is typed in
    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] addr;
        logic [2:0]  len;
        logic [31:0] data;
        bit          fixed;
        logic [31:0] rd;
        logic [1:0]  st;
    } t_access_row;

    t_access_result pending_results[$];
    logic [7:0]     mem_image[MEM_BYTES];
    bit             mem_written[MEM_BYTES];
    bit             paging_en = 1'b0;
    logic [19:0]    dir_frame = '0;
    int             errors = 0;
    int             accepted = 0;
    int             answered = 0;
    int             faults_seen = 0;
    int             cycles = 0;
    int             burst_left = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", answered, what, got, want);
        errors++;
    endtask

    // little-endian word from the memory image; flags bytes never written
    function automatic logic [31:0] image_word(input logic [31:0] a, inout bit safe);
        logic [31:0] v;
        int unsigned idx;
        v = '0;
        for (int i = 0; i < 4; i++) begin
            idx = (a + 32'(i)) & 32'(MEM_BYTES - 1);
            if (!mem_written[idx]) safe = 1'b0;
            v |= 32'(mem_image[idx]) << (8 * i);
        end
        return v;
    endfunction

    // two-level translation of one virtual address
    function automatic logic [1:0] translate_va(input logic [31:0] va, output longint pa,
                                                inout bit safe);
        logic [31:0] dir_addr, tab_addr, pde, pte;
        pa = 0;
        dir_addr = {dir_frame, 12'h000} + {20'h0, va[31:22], 2'b00};
        if (longint'(dir_addr) + 3 >= MEM_BYTES) return ST_RANGE;
        pde = image_word(dir_addr, safe);
        if (!pde[0]) return ST_NO_DIR;
        tab_addr = {pde[31:12], 12'h000} + {20'h0, va[21:12], 2'b00};
        if (longint'(tab_addr) + 3 >= MEM_BYTES) return ST_RANGE;
        pte = image_word(tab_addr, safe);
        if (!pte[0]) return ST_NO_TAB;
        pa = longint'({pte[31:12], va[11:0]});
        return ST_OK;
    endfunction

    // full access; commit updates the memory image, safe clears on reads of unset bytes
    function automatic void predict_access(input logic [1:0] cmd, input logic [31:0] addr,
                                           input logic [2:0] len_in, input logic [31:0] data,
                                           input bit commit, output t_access_result res,
                                           output bit safe);
        int unsigned len, len1, off;
        longint pa[4];
        longint p1, p2;
        logic [31:0] va2;
        safe = 1'b1;
        res.rd = '0;
        res.st = ST_OK;
        len = 32'(len_in);
        if (len == 0) return;
        if (len > 4) len = 4;
        if (cmd >= CMD_VRD && paging_en) begin
            off = 32'(addr[11:0]);
            len1 = (off + len > 4096) ? 4096 - off : len;
            res.st = translate_va(addr, p1, safe);
            va2 = addr + len1;
            if (res.st == ST_OK && len1 < len) res.st = translate_va(va2, p2, safe);
            if (res.st != ST_OK) return;
            for (int i = 0; i < len; i++) pa[i] = (i < len1) ? p1 + i : p2 + (i - len1);
        end else begin
            for (int i = 0; i < len; i++) pa[i] = longint'(addr) + i;
        end
        for (int i = 0; i < len; i++) begin
            if (pa[i] >= MEM_BYTES) begin
                res.st = ST_RANGE;
                return;
            end
        end
        for (int i = 0; i < len; i++) begin
            if (cmd[0]) begin
                if (commit) begin
                    mem_image[pa[i]] = data[8*i +: 8];
                    mem_written[pa[i]] = 1'b1;
                end
            end else begin
                if (!mem_written[pa[i]]) safe = 1'b0;
                res.rd |= 32'(mem_image[pa[i]]) << (8 * i);
            end
        end
    endfunction

    // sender: bursts of back-to-back transactions separated by random gaps
    task automatic send_access(input t_access_row row);
        t_access_result res;
        bit safe;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {3'b000, row.data, row.len, row.addr, row.cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        // transaction accepted: update the image in acceptance order
        predict_access(row.cmd, row.addr, row.len, row.data, 1'b1, res, safe);
        if (row.fixed) begin
            res.rd = row.rd;
            res.st = row.st;
        end
        pending_results.push_back(res);
        accepted++;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        burst_left = 0;
    endtask

    // register writes only while nothing is in flight
    task automatic write_reg(input logic [2:0] a, input logic [31:0] v);
        end_burst();
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = a;
        pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (a == REG_PAGING) paging_en = v[0];
        else dir_frame = v[19:0];
    endtask

    task automatic run_rows(input t_access_row rows[]);
        foreach (rows[i]) send_access(rows[i]);
    endtask

    // random item: mostly well-formed accesses through the mapped tables,
    // some plain physical traffic, some noise over all field bits
    task automatic pick_access(output t_access_row row);
        logic [9:0] dir_pick[6] = '{10'h000, 10'h001, 10'h002, 10'h003, 10'h155, 10'h3ff};
        logic [9:0] tab_pick[6] = '{10'h000, 10'h001, 10'h002, 10'h003, 10'h005, 10'h3ff};
        t_access_result res;
        bit safe;
        int kind;
        row.fixed = 1'b0;
        row.rd = '0;
        row.st = ST_OK;
        for (int tries = 0; tries < 60; tries++) begin
            kind = $urandom_range(0, 99);
            row.data = $urandom();
            row.len = 3'($urandom_range(1, 4));
            if (kind < 65) begin
                row.cmd = paging_en ? ($urandom_range(0, 1) ? CMD_VWR : CMD_VRD)
                                    : 2'($urandom_range(0, 3));
                if (paging_en) begin
                    row.addr[31:22] = dir_pick[$urandom_range(0, 5)];
                    row.addr[21:12] = tab_pick[$urandom_range(0, 5)];
                    row.addr[11:0]  = $urandom_range(0, 1) ? 12'($urandom())
                                                           : 12'($urandom_range(4092, 4095));
                end else begin
                    row.addr = $urandom_range(0, 3) != 0 ? $urandom_range(32'h4000, 32'hffff)
                                                         : $urandom_range(32'hfff8, 32'h10004);
                end
            end else if (kind < 85) begin
                row.cmd = $urandom_range(0, 1) ? CMD_PWR : CMD_PRD;
                row.addr = $urandom_range(32'h4000, 32'h10003);
            end else begin
                row.cmd = 2'($urandom());
                row.addr = $urandom();
                row.len = 3'($urandom());
            end
            predict_access(row.cmd, row.addr, row.len, row.data, 1'b0, res, safe);
            // never read bytes that were never written; try the write instead
            if (!safe) begin
                row.cmd[0] = 1'b1;
                predict_access(row.cmd, row.addr, row.len, row.data, 1'b0, res, safe);
            end
            if (safe) return;
        end
        row.cmd = CMD_PWR;
        row.addr = 32'h4000;
        row.len = 3'd4;
    endtask

    task automatic run_random(input int n);
        t_access_row row;
        repeat (n) begin
            pick_access(row);
            send_access(row);
        end
    endtask

    // receiver: stall pattern steps through four modes, chosen from the cycle counter
    always @(negedge i_clk) begin
        case ((cycles / 64) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (cycles % 7) < 3;
        endcase
    end

    // result checker
    always @(posedge i_clk) begin
        t_access_result want;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[33:32] != want.st)
                    report("status", 32'(m_axis_tdata[33:32]), 32'(want.st));
                if (m_axis_tdata[31:0] != want.rd)
                    report("read_data", m_axis_tdata[31:0], want.rd);
                if (want.st != ST_OK) faults_seen++;
            end
            answered++;
        end
    end

    // timeout guard
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        // paging off: plain physical accesses and their corner cases
        t_access_row phys_rows[] = '{
            '{CMD_PWR, 32'h00004000, 3'd4, 32'hdeadbeef, 1'b0, 32'h0, ST_OK},
            '{CMD_PRD, 32'h00004000, 3'd4, 32'h0, 1'b1, 32'hdeadbeef, ST_OK},
            '{CMD_PRD, 32'h00004001, 3'd2, 32'h0, 1'b1, 32'h0000adbe, ST_OK},
            '{CMD_PWR, 32'h0000fffc, 3'd4, 32'h01020304, 1'b0, 32'h0, ST_OK},
            '{CMD_PRD, 32'h0000ffff, 3'd1, 32'h0, 1'b1, 32'h00000001, ST_OK},
            '{CMD_PRD, 32'h0000fffe, 3'd4, 32'h0, 1'b1, 32'h0, ST_RANGE},
            '{CMD_PWR, 32'hffffffff, 3'd1, 32'hffffffff, 1'b1, 32'h0, ST_RANGE},
            '{CMD_PRD, 32'h00000000, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK},
            '{CMD_PWR, 32'h00004010, 3'd7, 32'hffffffff, 1'b1, 32'h0, ST_OK},
            '{CMD_PRD, 32'h00004010, 3'd4, 32'h0, 1'b1, 32'hffffffff, ST_OK},
            '{CMD_VWR, 32'h00004020, 3'd3, 32'h00a5a5a5, 1'b1, 32'h0, ST_OK},
            '{CMD_VRD, 32'h00004020, 3'd3, 32'h0, 1'b1, 32'h00a5a5a5, ST_OK},
            '{CMD_PWR, 32'h00004030, 3'd1, 32'h0, 1'b1, 32'h0, ST_OK},
            '{CMD_PRD, 32'h00004030, 3'd1, 32'h0, 1'b1, 32'h0, ST_OK}
        };
        // paging on with the directory at frame 1: walks, splits, wrap and faults
        t_access_row virt_rows[] = '{
            '{CMD_VWR, 32'h00000000, 3'd4, 32'h11223344, 1'b1, 32'h0, ST_OK},
            '{CMD_VRD, 32'h00000000, 3'd4, 32'h0, 1'b1, 32'h11223344, ST_OK},
            '{CMD_VWR, 32'h00000ffe, 3'd4, 32'hcafef00d, 1'b1, 32'h0, ST_OK},
            '{CMD_VRD, 32'h00000ffe, 3'd4, 32'h0, 1'b1, 32'hcafef00d, ST_OK},
            '{CMD_PRD, 32'h00004ffe, 3'd2, 32'h0, 1'b1, 32'h0000f00d, ST_OK},
            '{CMD_VWR, 32'hfffffffe, 3'd4, 32'h55667788, 1'b1, 32'h0, ST_OK},
            '{CMD_VRD, 32'hfffffffe, 3'd4, 32'h0, 1'b1, 32'h55667788, ST_OK},
            '{CMD_VRD, 32'h00800000, 3'd4, 32'h0, 1'b1, 32'h0, ST_NO_DIR},
            '{CMD_VRD, 32'h00002000, 3'd4, 32'h0, 1'b1, 32'h0, ST_NO_TAB},
            '{CMD_VRD, 32'h00c00000, 3'd4, 32'h0, 1'b1, 32'h0, ST_RANGE},
            '{CMD_VRD, 32'h00003000, 3'd1, 32'h0, 1'b1, 32'h0, ST_RANGE},
            '{CMD_VRD, 32'h00001ffe, 3'd4, 32'h0, 1'b1, 32'h0, ST_NO_TAB},
            '{CMD_VWR, 32'h00002ffe, 3'd4, 32'h99999999, 1'b1, 32'h0, ST_NO_TAB}
        };
        // directory at 0x1000, tables at 0x2000 and 0x3000, data frames 4 to 10;
        // includes absent entries and entries pointing beyond memory
        logic [31:0] table_words[][2] = '{
            '{32'h00001000, 32'h00002001}, '{32'h00001004, 32'h00003001},
            '{32'h00001008, 32'h00000000}, '{32'h0000100c, 32'h00100001},
            '{32'h00001554, 32'h00002001}, '{32'h00001ffc, 32'h00003001},
            '{32'h00002000, 32'h00004001}, '{32'h00002004, 32'h00005001},
            '{32'h00002008, 32'h00000000}, '{32'h0000200c, 32'h00100001},
            '{32'h00002ffc, 32'h00006001}, '{32'h00003000, 32'h00007001},
            '{32'h00003004, 32'h00008001}, '{32'h00003008, 32'h0000a001},
            '{32'h00003014, 32'h00000000}, '{32'h00003ffc, 32'h00009001}
        };
        t_access_row row;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(REG_PAGING, 32'd0);
        write_reg(REG_DIR_BASE, 32'd0);
        run_rows(phys_rows);
        run_random(250);

        // page tables go in through physical writes
        foreach (table_words[i]) begin
            row = '{CMD_PWR, table_words[i][0], 3'd4, table_words[i][1], 1'b0, 32'h0, ST_OK};
            send_access(row);
        end

        write_reg(REG_DIR_BASE, 32'd1);
        write_reg(REG_PAGING, 32'd1);
        run_rows(virt_rows);
        run_random(900);

        // directory base at its top: every walk runs beyond memory
        write_reg(REG_DIR_BASE, 32'hfffff);
        run_random(150);

        // paging off again with a nonzero base: virtual means physical
        write_reg(REG_PAGING, 32'd0);
        run_random(150);

        write_reg(REG_DIR_BASE, 32'd1);
        write_reg(REG_PAGING, 32'd1);
        run_random(200);

        end_burst();
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d access transactions over five register settings", accepted);
        $display("%0d results checked, %0d of them faults", answered, faults_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
